/* sv/phim_pkg.sv */
// Package: level codes, register indexes, widths and the result record.
`timescale 1ns / 1ps

package phim_pkg;

  localparam int DEF_MAX_K_STATES = 256;
  localparam int MOM_W            = 16;
  localparam int IDX_W            = 18;
  localparam int REG_IDX_W        = 1;

  typedef logic [1:0] level_t;

  localparam level_t LVL_GROUND = 2'd0;
  localparam level_t LVL_EXC1   = 2'd1;
  localparam level_t LVL_EXC2   = 2'd2;
  localparam level_t LVL_BAD    = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_K_MIN = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_K_MAX = 1'd1;

  typedef struct packed {
    logic [IDX_W-1:0] packed_index;
    logic             conjugate;
    logic             zero_entry;
    logic             invalid;
  } result_t;

endpackage

/* sv/phim_calc.sv */
// Index calculation: range checks, block selection and one shared multiply.
`timescale 1ns / 1ps

module phim_calc
  import phim_pkg::*;
#(
  parameter int MAX_K_STATES = DEF_MAX_K_STATES,
  localparam int KW = $clog2(MAX_K_STATES + 1),
  localparam int PW = 2 * KW + 2
) (
  input  logic signed [MOM_W-1:0] k_min,
  input  logic signed [MOM_W-1:0] k_max,
  input  logic        [KW-1:0]    k_cnt,
  input  logic        [PW-1:0]    t_blk,
  input  logic        [PW-1:0]    t3_blk,
  input  logic                    cfg_bad,
  input  level_t                  left_level,
  input  logic signed [MOM_W-1:0] left_momentum,
  input  level_t                  right_level,
  input  logic signed [MOM_W-1:0] right_momentum,
  output result_t                 res
);

  logic [MOM_W:0] diff_l;
  logic [MOM_W:0] diff_r;
  logic [KW-1:0]  a;
  logic [KW-1:0]  b;
  logic [KW-1:0]  lo;
  logic [KW-1:0]  hi;
  logic [KW-1:0]  y;
  logic [KW-1:0]  m1;
  logic [KW+1:0]  m2;
  logic [PW-1:0]  prod;
  logic [PW-1:0]  term;
  logic [PW-1:0]  base;
  logic [PW-1:0]  addv;
  logic [PW-1:0]  idx_full;
  logic           same;
  logic           coord_bad;

  assign diff_l = {left_momentum[MOM_W-1], left_momentum} - {k_min[MOM_W-1], k_min};
  assign diff_r = {right_momentum[MOM_W-1], right_momentum} - {k_min[MOM_W-1], k_min};
  assign a      = diff_l[KW-1:0];
  assign b      = diff_r[KW-1:0];

  assign coord_bad = (left_level == LVL_BAD) || (right_level == LVL_BAD) ||
                     (left_momentum < k_min) || (left_momentum > k_max) ||
                     (right_momentum < k_min) || (right_momentum > k_max);

  assign same = (left_level == right_level);
  assign lo   = (a <= b) ? a : b;
  assign hi   = (a <= b) ? b : a;
  assign y    = (left_level == LVL_EXC1) ? b : a;

  // tri(lo,hi) = lo*(2K+1-lo)/2 + (hi-lo); cross block = x*K + y
  assign m1   = same ? lo : ((left_level == LVL_EXC1) ? a : b);
  assign m2   = same ? ((KW+2)'({k_cnt, 1'b1}) - (KW+2)'(lo)) : (KW+2)'(k_cnt);
  assign prod = PW'(m1 * m2);
  assign term = same ? (prod >> 1) : prod;

  always_comb begin
    if (!same) begin
      base = t3_blk;
    end else if (left_level == LVL_EXC1) begin
      base = t_blk;
    end else if (left_level == LVL_EXC2) begin
      base = t_blk << 1;
    end else begin
      base = '0;
    end
  end

  assign addv     = same ? PW'(hi - lo) : PW'(y);
  assign idx_full = base + term + addv;

  always_comb begin
    res = '0;
    if (cfg_bad || coord_bad) begin
      res.invalid = 1'b1;
    end else if (same) begin
      res.packed_index = IDX_W'(idx_full);
      res.conjugate    = (a > b);
    end else if (left_level == LVL_GROUND || right_level == LVL_GROUND) begin
      res.zero_entry = 1'b1;
    end else begin
      res.packed_index = IDX_W'(idx_full);
      res.conjugate    = (left_level == LVL_EXC2);
    end
  end

endmodule

/* sv/packed_hermitian_index_map.sv */
// Top level: configuration registers, input register and result register.
`timescale 1ns / 1ps

// Maps a density-matrix coordinate (left level, left momentum, right level,
// right momentum) to its packed storage index with conjugate, zero and invalid
// flags. One request is accepted every cycle while in_stall is low; each request
// passes through the input register and then the result register, around
// a single pass of range checks and one shared multiplier. The block sizes
// K and T are recomputed from k_min and k_max in the cycle after a register write.
// Registers: index 0 is k_min, index 1 is k_max, both 16 bit signed, reset 0.

module packed_hermitian_index_map
  import phim_pkg::*;
#(
  parameter int MAX_K_STATES = DEF_MAX_K_STATES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [REG_IDX_W-1:0]    cfg_addr,
  input  logic [MOM_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  level_t                  left_level,
  input  logic signed [MOM_W-1:0] left_momentum,
  input  level_t                  right_level,
  input  logic signed [MOM_W-1:0] right_momentum,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        packed_index,
  output logic                    conjugate,
  output logic                    zero_entry,
  output logic                    invalid
);

  localparam int KW = $clog2(MAX_K_STATES + 1);
  localparam int PW = 2 * KW + 2;
  localparam logic [MOM_W-1:0] SPAN_LIM = MOM_W'(MAX_K_STATES);

  logic signed [MOM_W-1:0] k_min;
  logic signed [MOM_W-1:0] k_max;
  logic        [KW-1:0]    k_cnt;
  logic        [PW-1:0]    t_blk;
  logic        [PW-1:0]    t3_blk;
  logic                    cfg_bad;

  logic [MOM_W:0]  span;
  logic [KW-1:0]   k_cnt_next;
  logic [KW:0]     k_inc;
  logic [2*KW:0]   t_prod;
  logic [PW-1:0]   t_blk_next;
  logic [PW-1:0]   t3_blk_next;
  logic            cfg_bad_next;

  logic                    s1_valid;
  level_t                  s1_left_level;
  logic signed [MOM_W-1:0] s1_left_momentum;
  level_t                  s1_right_level;
  logic signed [MOM_W-1:0] s1_right_momentum;
  result_t                 calc_res;
  result_t                 out_res;
  logic                    out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_min <= '0;
      k_max <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_K_MIN: k_min <= cfg_data;
        REG_K_MAX: k_max <= cfg_data;
        default: ;
      endcase
    end
  end

  assign span         = {k_max[MOM_W-1], k_max} - {k_min[MOM_W-1], k_min};
  assign cfg_bad_next = span[MOM_W] || (span[MOM_W-1:0] >= SPAN_LIM);
  assign k_cnt_next   = KW'(span[MOM_W-1:0] + MOM_W'(1));
  assign k_inc        = {1'b0, k_cnt} + (KW+1)'(1);
  assign t_prod       = (2*KW+1)'(k_cnt * k_inc);
  assign t_blk_next   = PW'(t_prod >> 1);
  assign t3_blk_next  = t_blk_next + (t_blk_next << 1);

  // register the derived block sizes behind the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k_cnt   <= KW'(1);
      t_blk   <= PW'(1);
      t3_blk  <= PW'(3);
      cfg_bad <= 1'b0;
    end else begin
      k_cnt   <= k_cnt_next;
      t_blk   <= t_blk_next;
      t3_blk  <= t3_blk_next;
      cfg_bad <= cfg_bad_next;
    end
  end

  assign out_load = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_left_level     <= left_level;
      s1_left_momentum  <= left_momentum;
      s1_right_level    <= right_level;
      s1_right_momentum <= right_momentum;
    end
  end

  phim_calc #(
    .MAX_K_STATES(MAX_K_STATES)
  ) u_calc (
    .k_min          (k_min),
    .k_max          (k_max),
    .k_cnt          (k_cnt),
    .t_blk          (t_blk),
    .t3_blk         (t3_blk),
    .cfg_bad        (cfg_bad),
    .left_level     (s1_left_level),
    .left_momentum  (s1_left_momentum),
    .right_level    (s1_right_level),
    .right_momentum (s1_right_momentum),
    .res            (calc_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      out_res <= calc_res;
    end
  end

  assign packed_index = out_res.packed_index;
  assign conjugate    = out_res.conjugate;
  assign zero_entry   = out_res.zero_entry;
  assign invalid      = out_res.invalid;

  a_invalid_clears : assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> packed_index == '0 && !conjugate && !zero_entry)
    else $error("invalid result carries index or flags");

  a_zero_clears : assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_entry |-> packed_index == '0 && !conjugate)
    else $error("zero entry carries index or conjugate");

  a_accept_fills : assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("accepted request lost from input register");

  a_stall_holds_s1 : assert property (@(posedge clk) disable iff (rst)
    in_stall |=> s1_valid && $stable(s1_left_momentum) && $stable(s1_right_momentum))
    else $error("input register changed while stalled");

endmodule

/* bench/tb.sv */
// Testbench for packed_hermitian_index_map: directed and random coordinates vs a predictor.
`timescale 1ns / 1ps

module tb;
  import phim_pkg::*;

  localparam int MAX_K      = DEF_MAX_K_STATES;
  localparam int NUM_LEVELS = 3;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [REG_IDX_W-1:0]    cfg_addr = REG_K_MIN;
  logic [MOM_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  level_t                  left_level = LVL_GROUND;
  logic signed [MOM_W-1:0] left_momentum = '0;
  level_t                  right_level = LVL_GROUND;
  logic signed [MOM_W-1:0] right_momentum = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [IDX_W-1:0]        packed_index;
  logic                    conjugate;
  logic                    zero_entry;
  logic                    invalid;

  logic signed [MOM_W-1:0] range_lo = '0;
  logic signed [MOM_W-1:0] range_hi = '0;
  bit                      idle_on = 1'b1;
  int                      stall_left = 0;
  int                      n_errors = 0;
  int                      n_requests = 0;
  int                      n_results = 0;
  int                      n_ranges = 1;
  result_t                 pending_idx_q[$];

  packed_hermitian_index_map #(
    .MAX_K_STATES(MAX_K)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .left_level(left_level),
    .left_momentum(left_momentum),
    .right_level(right_level),
    .right_momentum(right_momentum),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .packed_index(packed_index),
    .conjugate(conjugate),
    .zero_entry(zero_entry),
    .invalid(invalid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint tri_offset(longint a, longint b, longint k);
    return a * k - (a * (a - 1)) / 2 + (b - a);
  endfunction

  function automatic result_t map_coord(level_t nl, logic signed [MOM_W-1:0] kl,
                                        level_t nr, logic signed [MOM_W-1:0] kr);
    longint  lo, hi, k, t, a, b, idx;
    result_t r;
    r   = '0;
    idx = 0;
    lo  = range_lo;
    hi  = range_hi;
    if (lo > hi || hi - lo + 1 > MAX_K || nl == LVL_BAD || nr == LVL_BAD ||
        kl < lo || kl > hi || kr < lo || kr > hi) begin
      r.invalid = 1'b1;
    end else begin
      k = hi - lo + 1;
      t = k * (k + 1) / 2;
      a = kl - lo;
      b = kr - lo;
      if (nl == nr) begin
        if (a <= b) begin
          idx = longint'(nl) * t + tri_offset(a, b, k);
        end else begin
          idx = longint'(nl) * t + tri_offset(b, a, k);
          r.conjugate = 1'b1;
        end
      end else if (nl == LVL_GROUND || nr == LVL_GROUND) begin
        r.zero_entry = 1'b1;
      end else if (nl == LVL_EXC1) begin
        idx = NUM_LEVELS * t + a * k + b;
      end else begin
        idx = NUM_LEVELS * t + b * k + a;
        r.conjugate = 1'b1;
      end
    end
    r.packed_index = idx[IDX_W-1:0];
    return r;
  endfunction

  function automatic void queue_expected(result_t r);
    pending_idx_q.insert(pending_idx_q.size(), r);
  endfunction

  function automatic void report_mismatch(string what, result_t exp_r, result_t got_r);
    n_errors++;
    if (n_errors <= 10) begin
      $display("%0t %s: expected idx=%0d conj=%0b zero=%0b inv=%0b,",
               $realtime, what, exp_r.packed_index, exp_r.conjugate, exp_r.zero_entry,
               exp_r.invalid);
      $display("    got idx=%0d conj=%0b zero=%0b inv=%0b",
               got_r.packed_index, got_r.conjugate, got_r.zero_entry, got_r.invalid);
    end
  endfunction

  always @(posedge clk) begin
    result_t exp_r, got_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_results++;
        got_r = '{packed_index, conjugate, zero_entry, invalid};
        if (pending_idx_q.size() == 0) begin
          report_mismatch("result with no request pending", '0, got_r);
        end else begin
          exp_r = pending_idx_q.pop_front();
          if (got_r.packed_index != exp_r.packed_index || got_r.conjugate != exp_r.conjugate ||
              got_r.zero_entry != exp_r.zero_entry || got_r.invalid != exp_r.invalid) begin
            report_mismatch("index mismatch", exp_r, got_r);
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_requests++;
        queue_expected(map_coord(left_level, left_momentum, right_level, right_momentum));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_coord(level_t nl, logic signed [MOM_W-1:0] kl,
                            level_t nr, logic signed [MOM_W-1:0] kr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    left_level     <= nl;
    left_momentum  <= kl;
    right_level    <= nr;
    right_momentum <= kr;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // hold off new requests until every pending result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_idx_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_range(logic signed [MOM_W-1:0] lo, logic signed [MOM_W-1:0] hi);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_addr <= REG_K_MIN;
    cfg_data <= lo;
    @(posedge clk);
    cfg_addr <= REG_K_MAX;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we   <= 1'b0;
    range_lo = lo;
    range_hi = hi;
    n_ranges++;
    repeat (3) @(posedge clk);
  endtask

  function automatic logic signed [MOM_W-1:0] pick_momentum();
    int sel;
    sel = $urandom_range(0, 9);
    if (range_lo > range_hi) return MOM_W'($urandom);
    if (sel == 0) return range_lo;
    if (sel == 1) return range_hi;
    return MOM_W'(range_lo + $urandom_range(0, int'(range_hi) - int'(range_lo)));
  endfunction

  task automatic send_random(int noise_pct);
    level_t                  nl, nr;
    logic signed [MOM_W-1:0] kl, kr;
    nl = level_t'($urandom_range(0, 2));
    nr = level_t'($urandom_range(0, 2));
    kl = pick_momentum();
    kr = pick_momentum();
    if ($urandom_range(0, 99) < noise_pct) begin
      case ($urandom_range(0, 3))
        0: nl = LVL_BAD;
        1: nr = LVL_BAD;
        2: kl = MOM_W'($urandom);
        default: kr = MOM_W'($urandom);
      endcase
    end
    send_coord(nl, kl, nr, kr);
  endtask

  task automatic test_reset_range();
    send_coord(LVL_GROUND, 0, LVL_GROUND, 0);
    send_coord(LVL_EXC1, 0, LVL_EXC2, 0);
    send_coord(LVL_EXC2, 0, LVL_EXC2, 0);
  endtask

  task automatic test_small_range();
    set_range(-3, 4);
    send_coord(LVL_GROUND, -3, LVL_GROUND, 4);
    send_coord(LVL_EXC1, 4, LVL_EXC1, -3);
    send_coord(LVL_EXC2, 4, LVL_EXC2, 4);
    send_coord(LVL_EXC1, -3, LVL_EXC2, 4);
    send_coord(LVL_EXC2, 4, LVL_EXC1, -3);
    send_coord(LVL_GROUND, 0, LVL_EXC1, 0);
    send_coord(LVL_EXC2, 1, LVL_GROUND, 1);
    send_coord(LVL_BAD, 0, LVL_GROUND, 0);
    send_coord(LVL_GROUND, 0, LVL_BAD, 0);
    send_coord(LVL_EXC1, -4, LVL_EXC1, 0);
    send_coord(LVL_EXC1, 0, LVL_EXC1, 5);
    send_coord(LVL_GROUND, -32768, LVL_GROUND, 32767);
  endtask

  task automatic test_extreme_ranges();
    set_range(-32768, -32513);
    send_coord(LVL_EXC1, -32513, LVL_EXC2, -32513);
    send_coord(LVL_EXC2, -32768, LVL_EXC1, -32513);
    set_range(32512, 32767);
    send_coord(LVL_EXC2, 32767, LVL_EXC2, 32512);
    send_coord(LVL_GROUND, 32767, LVL_GROUND, 32767);
  endtask

  task automatic test_bad_config();
    set_range(0, 256);
    send_coord(LVL_GROUND, 0, LVL_GROUND, 0);
    set_range(5, 4);
    send_coord(LVL_GROUND, 4, LVL_GROUND, 5);
    set_range(-32768, 32767);
    send_coord(LVL_EXC1, 0, LVL_EXC1, 0);
  endtask

  task automatic test_random();
    int k, lo;
    for (int phase = 0; phase < 13; phase++) begin
      case (phase)
        0: k = MAX_K;
        1: k = MAX_K;
        2: k = 1;
        3: k = 0;
        4: k = MAX_K + 1;
        default: begin
          k = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom_range(1, MAX_K);
        end
      endcase
      case (phase)
        0: lo = -32768;
        1: lo = 32768 - k;
        default: lo = $urandom_range(0, 65536 - k) - 32768;
      endcase
      if (k == 0) begin
        set_range(MOM_W'(lo + 1), MOM_W'(lo));
      end else begin
        set_range(MOM_W'(lo), MOM_W'(lo + k - 1));
      end
      if (phase == 12) idle_on = 1'b0;
      for (int n = 0; n < 130; n++) begin
        if (phase == 6 && n == 65) drain_results();
        send_random(15);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_range();
    test_small_range();
    test_extreme_ranges();
    test_bad_config();
    test_random();
    drain_results();
    repeat (4) @(posedge clk);
    $display("Checked %0d results for %0d coordinate requests across %0d momentum ranges,",
             n_results, n_requests, n_ranges);
    $display("including full-size, single-state and misconfigured ranges; %0d mismatches.",
             n_errors);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
